// ===== sv/bwt_pkg.sv =====
// Shared types and constants for the box wireframe transform.
package bwt_pkg;

  localparam int CORNERS  = 8;
  localparam int EDGES    = 12;
  localparam int COORD_W  = 20;
  localparam int PROD_W   = 36;
  localparam int PIX_W    = 14;
  localparam int CORNER_W = 2 * PIX_W;
  localparam int SIN_ONE  = 16384;
  localparam int SIN_A    = 25736;
  localparam int SIN_B    = 10512;
  localparam int SIN_C    = 1160;
  localparam int PIX_MAX  = 8191;
  localparam int PIX_MIN  = -8192;

  typedef enum logic [1:0] {
    ANCHOR_CENTER = 2'd0,
    ANCHOR_TLF    = 2'd1,
    ANCHOR_BLF    = 2'd2,
    ANCHOR_ALT    = 2'd3
  } bwt_anchor_e;

  // Front to corner queue: one corner write per transfer, done on the last corner.
  typedef struct packed {
    logic                wr_en;
    logic [2:0]          wr_corner;
    logic [CORNER_W-1:0] wr_data;
    logic                done;
    logic [31:0]         color;
  } bwt_front_st_t;

endpackage

// ===== sv/bwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bwt_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/bwt_front.sv =====
// Front end: takes a box, builds sine/cosine, rotates and projects the eight corners.
module bwt_front #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int ANGLE_BITS      = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic signed [15:0]   ref_x_i,
  input  logic signed [15:0]   ref_y_i,
  input  logic [15:0]          box_length_i,
  input  logic [15:0]          box_width_i,
  input  logic [15:0]          box_height_i,
  input  logic [15:0]          pitch_angle_i,
  input  logic [15:0]          yaw_angle_i,
  input  logic [15:0]          roll_angle_i,
  input  logic [1:0]           anchor_mode_i,
  input  logic [31:0]          edge_color_i,
  output logic                 busy_o,
  output bwt_pkg::bwt_front_st_t st_o
);
  import bwt_pkg::*;

  localparam int SH = COORD_FRAC_BITS + 1;
  localparam int SUM_W = PROD_W + 1;

  typedef enum logic [5:0] {
    F_IDLE  = 6'b000001,
    F_TRIG  = 6'b000010,
    F_LOAD  = 6'b000100,
    F_MUL   = 6'b001000,
    F_ADD   = 6'b010000,
    F_WRITE = 6'b100000
  } bwt_front_state_e;

  bwt_front_state_e state_q, state_d;

  logic [2:0]            trig_idx_q;
  logic [1:0]            trig_ph_q;
  logic [2:0]            corner_q;
  logic [1:0]            rot_q;

  logic signed [15:0]    ref_x_q, ref_y_q;
  logic [15:0]           hx_q, hy_q, hz_q;
  logic [ANGLE_BITS-1:0] ang_q [3];
  logic [1:0]            mode_q;
  logic [31:0]           color_q;

  logic [14:0]           t_q, t2_q, pk_q;
  logic                  neg_q;
  logic signed [15:0]    trig_q [6];

  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic signed [PROD_W-1:0]  uc_q, vs_q, us_q, vc_q;

  // ---- sine/cosine sequencer: one 15x15 multiply per cycle ----
  logic [ANGLE_BITS-1:0] ang_sel;
  logic [15:0]           a16;
  logic [14:0]           t_in, ma, mb;
  logic [29:0]           prod;
  logic [15:0]           prod_sh;
  logic [15:0]           r_clamp;

  always_comb begin
    case (trig_idx_q[2:1])
      2'd0:    ang_sel = ang_q[0];
      2'd1:    ang_sel = ang_q[1];
      default: ang_sel = ang_q[2];
    endcase
    a16 = (16'(ang_sel) << (16 - ANGLE_BITS)) + (trig_idx_q[0] ? 16'd16384 : 16'd0);
    t_in = a16[14] ? (15'(SIN_ONE) - {1'b0, a16[13:0]}) : {1'b0, a16[13:0]};
    case (trig_ph_q)
      2'd0:    begin ma = t_in;        mb = t_in; end
      2'd1:    begin ma = 15'(SIN_C);  mb = t2_q; end
      2'd2:    begin ma = t2_q;        mb = pk_q; end
      default: begin ma = t_q;         mb = pk_q; end
    endcase
    prod    = 30'(ma) * 30'(mb);
    prod_sh = prod[29:14];
    r_clamp = (prod_sh > 16'(SIN_ONE)) ? 16'(SIN_ONE) : prod_sh;
  end

  // ---- corner setup from half extents and anchor ----
  logic signed [COORD_W-1:0] hx_s, hy_s, hz_s, ox, oy, oz;
  logic signed [COORD_W-1:0] init_x, init_y, init_z;

  always_comb begin
    hx_s = $signed(COORD_W'(hx_q));
    hy_s = $signed(COORD_W'(hy_q));
    hz_s = $signed(COORD_W'(hz_q));
    ox = '0;
    oy = '0;
    oz = '0;
    case (mode_q)
      ANCHOR_TLF: begin ox = hx_s; oy = -hy_s; oz = -hz_s; end
      ANCHOR_BLF: begin ox = hx_s; oy = hy_s;  oz = -hz_s; end
      default:    begin ox = '0;   oy = '0;    oz = '0;    end
    endcase
    init_x = ((corner_q[0] ^ corner_q[1]) ? hx_s : -hx_s) - ox;
    init_y = (corner_q[1] ? hy_s : -hy_s) - oy;
    init_z = (corner_q[2] ? hz_s : -hz_s) - oz;
  end

  // ---- rotation about one axis ----
  logic signed [COORD_W-1:0] rot_u, rot_v;
  logic signed [15:0]        rot_c, rot_s;
  logic signed [SUM_W-1:0]   nu, nv;
  logic signed [COORD_W-1:0] nu_c, nv_c;

  always_comb begin
    case (rot_q)
      2'd0:    begin rot_u = y_q; rot_v = z_q; rot_c = trig_q[1]; rot_s = trig_q[0]; end
      2'd1:    begin rot_u = z_q; rot_v = x_q; rot_c = trig_q[3]; rot_s = trig_q[2]; end
      default: begin rot_u = x_q; rot_v = y_q; rot_c = trig_q[5]; rot_s = trig_q[4]; end
    endcase
    nu = SUM_W'(uc_q) - SUM_W'(vs_q) + SUM_W'(8192);
    nv = SUM_W'(us_q) + SUM_W'(vc_q) + SUM_W'(8192);
    nu_c = nu[COORD_W+13:14];
    nv_c = nv[COORD_W+13:14];
  end

  // ---- reference add, truncate toward zero, saturate ----
  function automatic logic [PIX_W-1:0] to_pix(input logic signed [COORD_W-1:0] v,
                                               input logic signed [15:0] r);
    logic signed [COORD_W:0] s;
    logic signed [COORD_W:0] t;
    logic [PIX_W-1:0]        p;
    s = (COORD_W+1)'(v) + (COORD_W+1)'($signed({r, 1'b0}));
    t = s[COORD_W] ? ((s + (COORD_W+1)'((1 << SH) - 1)) >>> SH) : (s >>> SH);
    if (t > PIX_MAX) begin
      p = PIX_W'(PIX_MAX);
    end else if (t < PIX_MIN) begin
      p = PIX_W'(PIX_MIN);
    end else begin
      p = t[PIX_W-1:0];
    end
    return p;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept_i) state_d = F_TRIG;
      F_TRIG:  if (trig_ph_q == 2'd3 && trig_idx_q == 3'd5) state_d = F_LOAD;
      F_LOAD:  state_d = F_MUL;
      F_MUL:   state_d = F_ADD;
      F_ADD:   if (rot_q == 2'd2) state_d = F_WRITE; else state_d = F_MUL;
      F_WRITE: if (corner_q == 3'd7) state_d = F_IDLE; else state_d = F_LOAD;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      trig_idx_q <= '0;
      trig_ph_q  <= '0;
      corner_q   <= '0;
      rot_q      <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        F_IDLE: begin
          trig_idx_q <= '0;
          trig_ph_q  <= '0;
          corner_q   <= '0;
          rot_q      <= '0;
        end
        F_TRIG: begin
          trig_ph_q <= trig_ph_q + 2'd1;
          if (trig_ph_q == 2'd3) trig_idx_q <= trig_idx_q + 3'd1;
        end
        F_LOAD:  rot_q <= '0;
        F_ADD:   rot_q <= rot_q + 2'd1;
        F_WRITE: corner_q <= corner_q + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && accept_i) begin
      ref_x_q  <= ref_x_i;
      ref_y_q  <= ref_y_i;
      hx_q     <= box_length_i;
      hz_q     <= box_width_i;
      hy_q     <= box_height_i;
      ang_q[0] <= pitch_angle_i[15 -: ANGLE_BITS];
      ang_q[1] <= yaw_angle_i[15 -: ANGLE_BITS];
      ang_q[2] <= roll_angle_i[15 -: ANGLE_BITS];
      mode_q   <= anchor_mode_i;
      color_q  <= edge_color_i;
    end
    if (state_q == F_TRIG) begin
      case (trig_ph_q)
        2'd0: begin
          t_q   <= t_in;
          t2_q  <= prod_sh[14:0];
          neg_q <= a16[15];
        end
        2'd1:    pk_q <= 15'(SIN_B) - prod_sh[14:0];
        2'd2:    pk_q <= 15'(SIN_A) - prod_sh[14:0];
        default: trig_q[trig_idx_q] <= neg_q ? -$signed(r_clamp) : $signed(r_clamp);
      endcase
    end
    if (state_q == F_LOAD) begin
      x_q <= init_x;
      y_q <= init_y;
      z_q <= init_z;
    end
    if (state_q == F_MUL) begin
      uc_q <= rot_u * rot_c;
      vs_q <= rot_v * rot_s;
      us_q <= rot_u * rot_s;
      vc_q <= rot_v * rot_c;
    end
    if (state_q == F_ADD) begin
      case (rot_q)
        2'd0:    begin y_q <= nu_c; z_q <= nv_c; end
        2'd1:    begin z_q <= nu_c; x_q <= nv_c; end
        default: begin x_q <= nu_c; y_q <= nv_c; end
      endcase
    end
  end

  assign busy_o          = (state_q != F_IDLE);
  assign st_o.wr_en      = (state_q == F_WRITE);
  assign st_o.wr_corner  = corner_q;
  assign st_o.wr_data    = {to_pix(x_q, ref_x_q), to_pix(y_q, ref_y_q)};
  assign st_o.done       = (state_q == F_WRITE) && (corner_q == 3'd7);
  assign st_o.color      = color_q;

endmodule

// ===== sv/bwt_back.sv =====
// Back end: walks every edge of a queued box and presents them as results.
module bwt_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          avail_i,
  input  logic [31:0]                   color_i,
  output logic                          rd_en_o,
  output logic [2:0]                    rd_a_o,
  output logic [2:0]                    rd_b_o,
  input  logic [bwt_pkg::CORNER_W-1:0]  rdata_a_i,
  input  logic [bwt_pkg::CORNER_W-1:0]  rdata_b_i,
  output logic                          free_o,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic signed [13:0]            x_start_o,
  output logic signed [13:0]            y_start_o,
  output logic signed [13:0]            x_end_o,
  output logic signed [13:0]            y_end_o,
  output logic [31:0]                   line_color_o,
  output logic                          last_edge_o
);
  import bwt_pkg::*;

  function automatic logic [5:0] edge_pair(input logic [3:0] e);
    logic [5:0] p;
    case (e)
      4'd0:    p = {3'd0, 3'd1};
      4'd1:    p = {3'd1, 3'd2};
      4'd2:    p = {3'd2, 3'd3};
      4'd3:    p = {3'd3, 3'd0};
      4'd4:    p = {3'd4, 3'd5};
      4'd5:    p = {3'd5, 3'd6};
      4'd6:    p = {3'd6, 3'd7};
      4'd7:    p = {3'd7, 3'd4};
      4'd8:    p = {3'd0, 3'd4};
      4'd9:    p = {3'd1, 3'd5};
      4'd10:   p = {3'd2, 3'd6};
      default: p = {3'd3, 3'd7};
    endcase
    return p;
  endfunction

  logic [3:0] edge_q;
  logic       infl_q, last_rd_q, ov_q;
  logic       issue;

  assign issue   = avail_i && !infl_q && (!ov_q || pop_i);
  assign rd_en_o = issue;
  assign {rd_a_o, rd_b_o} = edge_pair(edge_q);
  assign free_o  = infl_q && last_rd_q;
  assign empty_o = !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q    <= '0;
      infl_q    <= 1'b0;
      last_rd_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      infl_q <= issue;
      if (issue) begin
        last_rd_q <= (edge_q == 4'(EDGES - 1));
        edge_q    <= (edge_q == 4'(EDGES - 1)) ? 4'd0 : edge_q + 4'd1;
      end
      if (infl_q) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (infl_q) begin
      x_start_o    <= rdata_a_i[CORNER_W-1:PIX_W];
      y_start_o    <= rdata_a_i[PIX_W-1:0];
      x_end_o      <= rdata_b_i[CORNER_W-1:PIX_W];
      y_end_o      <= rdata_b_i[PIX_W-1:0];
      line_color_o <= color_i;
      last_edge_o  <= last_rd_q;
    end
  end

endmodule

// ===== sv/box_wireframe_transform.sv =====
// Top level of the box wireframe transform: front end, corner queue, edge back end.
//
// One box goes in and all of its edges come out, in the order of the four front edges,
// the four back edges and then the four side edges, each with both endpoints in
// saturated integer pixels, the box colour and last_edge_o set on the twelfth.
// The front end owns one box at a time: it first builds the six sine and cosine
// values on a single shared 15x15 multiplier, then handles each corner in turn
// (load, three rotations of a multiply and an add step each, project and write),
// and takes no new box until its last corner is written. Corners go into a
// two-box queue built from two corner RAMs, so a new box can be taken while the
// previous one is still draining; full is high while the front end is busy or
// both queue slots are taken. The back end reads each edge from the RAM into the
// result register and starts no new read until that edge is registered, so edges
// are not read back to back. ref_z_i is accepted but has no effect on any result.
module box_wireframe_transform #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int ANGLE_BITS      = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] ref_x_i,
  input  logic signed [15:0] ref_y_i,
  input  logic signed [15:0] ref_z_i,
  input  logic [15:0]        box_length_i,
  input  logic [15:0]        box_width_i,
  input  logic [15:0]        box_height_i,
  input  logic [15:0]        pitch_angle_i,
  input  logic [15:0]        yaw_angle_i,
  input  logic [15:0]        roll_angle_i,
  input  logic [1:0]         anchor_mode_i,
  input  logic [31:0]        edge_color_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [13:0] x_start_o,
  output logic signed [13:0] y_start_o,
  output logic signed [13:0] x_end_o,
  output logic signed [13:0] y_end_o,
  output logic [31:0]        line_color_o,
  output logic               last_edge_o
);
  import bwt_pkg::*;

  bwt_front_st_t       front_st;
  logic                front_busy;
  logic                accept;

  // corner queue bookkeeping: two slots of eight corners each
  logic                wr_slot_q, rd_slot_q;
  logic [1:0]          cnt_q;
  logic [31:0]         color_q [2];

  logic                rd_en, set_free;
  logic [2:0]          rd_a, rd_b;
  logic [CORNER_W-1:0] rdata_a, rdata_b;

  assign full   = front_busy || (cnt_q == 2'd2);
  assign accept = push && !full;

  bwt_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .ANGLE_BITS     (ANGLE_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .ref_x_i       (ref_x_i),
    .ref_y_i       (ref_y_i),
    .box_length_i  (box_length_i),
    .box_width_i   (box_width_i),
    .box_height_i  (box_height_i),
    .pitch_angle_i (pitch_angle_i),
    .yaw_angle_i   (yaw_angle_i),
    .roll_angle_i  (roll_angle_i),
    .anchor_mode_i (anchor_mode_i),
    .edge_color_i  (edge_color_i),
    .busy_o        (front_busy),
    .st_o          (front_st)
  );

  // Two copies so both endpoints of an edge are read in the same cycle.
  bwt_ram #(.WIDTH(CORNER_W), .DEPTH(2 * CORNERS)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (front_st.wr_en),
    .waddr_i ({wr_slot_q, front_st.wr_corner}),
    .wdata_i (front_st.wr_data),
    .re_i    (rd_en),
    .raddr_i ({rd_slot_q, rd_a}),
    .rdata_o (rdata_a)
  );

  bwt_ram #(.WIDTH(CORNER_W), .DEPTH(2 * CORNERS)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (front_st.wr_en),
    .waddr_i ({wr_slot_q, front_st.wr_corner}),
    .wdata_i (front_st.wr_data),
    .re_i    (rd_en),
    .raddr_i ({rd_slot_q, rd_b}),
    .rdata_o (rdata_b)
  );

  bwt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (cnt_q != 2'd0),
    .color_i      (color_q[rd_slot_q]),
    .rd_en_o      (rd_en),
    .rd_a_o       (rd_a),
    .rd_b_o       (rd_b),
    .rdata_a_i    (rdata_a),
    .rdata_b_i    (rdata_b),
    .free_o       (set_free),
    .pop_i        (pop),
    .empty_o      (empty),
    .x_start_o    (x_start_o),
    .y_start_o    (y_start_o),
    .x_end_o      (x_end_o),
    .y_end_o      (y_end_o),
    .line_color_o (line_color_o),
    .last_edge_o  (last_edge_o)
  );

  // A slot is handed over when its last corner is written and returned
  // once the twelfth edge has left the RAM.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q <= 1'b0;
      rd_slot_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (front_st.done) wr_slot_q <= !wr_slot_q;
      if (set_free)      rd_slot_q <= !rd_slot_q;
      case ({front_st.done, set_free})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_st.done) color_q[wr_slot_q] <= front_st.color;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("corner queue count out of range");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.done |-> cnt_q != 2'd2)
    else $error("box finished with both queue slots taken");

  a_read_needs_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> cnt_q != 2'd0)
    else $error("edge read with no box queued");

  a_free_needs_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_free |-> cnt_q != 2'd0)
    else $error("slot released with no box queued");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the box wireframe transform: queue handshakes on both sides.
`timescale 1ns / 100ps

module testbench;
  import bwt_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_LEN   = 10;
  localparam int RAND_BOXES  = 320;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HOLD_LEN    = 1500;

  // one box as driven on the input ports
  typedef struct {
    logic signed [15:0] rx, ry, rz;
    logic [15:0]        len, wid, hgt;
    logic [15:0]        pitch, yaw, roll;
    logic [1:0]         anchor;
    logic [31:0]        color;
  } box_t;

  // one edge as seen on the result ports
  typedef struct {
    logic [13:0] xs, ys, xe, ye;
    logic [31:0] color;
    logic        last;
  } edge_t;

  // Predicts every edge of each box and checks edges against them in order.
  class edge_scoreboard;
    edge_t pending[$];
    int    errors;

    function int unsigned quarter_sine(int unsigned t);
      int unsigned t2, p1, p2, r;
      t2 = (t * t) >> 14;
      p1 = (SIN_C * t2) >> 14;
      p2 = (t2 * (SIN_B - p1)) >> 14;
      r  = (t * (SIN_A - p2)) >> 14;
      return (r > SIN_ONE) ? SIN_ONE : r;
    endfunction

    function longint bin_sine(logic [15:0] ang);
      logic [1:0]  q;
      int unsigned t;
      longint      v;
      q = ang[15:14];
      t = ang[13:0];
      if (q[0]) t = SIN_ONE - t;
      v = quarter_sine(t);
      return q[1] ? -v : v;
    endfunction

    // rounded rotation stage: (u, v) -> (u*c - v*s, u*s + v*c)
    function void rotate(inout longint u, inout longint v, input longint c, input longint s);
      longint nu, nv;
      nu = u * c - v * s;
      nv = u * s + v * c;
      u = (nu + 8192) >>> 14;
      v = (nv + 8192) >>> 14;
    endfunction

    function logic [13:0] pixel(longint v);
      longint p;
      p = (v >= 0) ? (v >>> 5) : -((-v) >>> 5);
      if (p > PIX_MAX) p = PIX_MAX;
      if (p < PIX_MIN) p = PIX_MIN;
      return p[13:0];
    endfunction

    function void note_box(box_t b);
      int          pairs [EDGES][2] = '{'{0, 1}, '{1, 2}, '{2, 3}, '{3, 0},
                                        '{4, 5}, '{5, 6}, '{6, 7}, '{7, 4},
                                        '{0, 4}, '{1, 5}, '{2, 6}, '{3, 7}};
      logic [13:0] px [CORNERS];
      logic [13:0] py [CORNERS];
      longint      hx, hy, hz, ox, oy, oz, x, y, z;
      longint      cp, sp, cy, sy, cr, sr;
      edge_t       e;
      hx = b.len; hy = b.hgt; hz = b.wid;
      ox = 0; oy = 0; oz = 0;
      cp = bin_sine(b.pitch + 16'd16384); sp = bin_sine(b.pitch);
      cy = bin_sine(b.yaw + 16'd16384);   sy = bin_sine(b.yaw);
      cr = bin_sine(b.roll + 16'd16384);  sr = bin_sine(b.roll);
      if (b.anchor == ANCHOR_TLF) begin
        ox = hx; oy = -hy; oz = -hz;
      end else if (b.anchor == ANCHOR_BLF) begin
        ox = hx; oy = hy; oz = -hz;
      end
      for (int i = 0; i < CORNERS; i++) begin
        x = ((i == 1 || i == 2 || i == 5 || i == 6) ? hx : -hx) - ox;
        y = ((i & 2) ? hy : -hy) - oy;
        z = ((i & 4) ? hz : -hz) - oz;
        rotate(y, z, cp, sp);
        rotate(z, x, cy, sy);
        rotate(x, y, cr, sr);
        px[i] = pixel(x + 2 * longint'(b.rx));
        py[i] = pixel(y + 2 * longint'(b.ry));
      end
      for (int k = 0; k < EDGES; k++) begin
        e.xs = px[pairs[k][0]]; e.ys = py[pairs[k][0]];
        e.xe = px[pairs[k][1]]; e.ye = py[pairs[k][1]];
        e.color = b.color;
        e.last  = (k == EDGES - 1);
        pending.push_back(e);
      end
    endfunction

    function void check_edge(edge_t a);
      edge_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected edge xs=%0d ys=%0d", $time, $signed(a.xs), $signed(a.ys));
        errors++;
        return;
      end
      w = pending.pop_front();
      if (a.xs !== w.xs) begin
        $display("%0t: x_start exp %0d got %0d", $time, $signed(w.xs), $signed(a.xs));
        errors++;
      end
      if (a.ys !== w.ys) begin
        $display("%0t: y_start exp %0d got %0d", $time, $signed(w.ys), $signed(a.ys));
        errors++;
      end
      if (a.xe !== w.xe) begin
        $display("%0t: x_end exp %0d got %0d", $time, $signed(w.xe), $signed(a.xe));
        errors++;
      end
      if (a.ye !== w.ye) begin
        $display("%0t: y_end exp %0d got %0d", $time, $signed(w.ye), $signed(a.ye));
        errors++;
      end
      if (a.color !== w.color) begin
        $display("%0t: line_color exp %h got %h", $time, w.color, a.color);
        errors++;
      end
      if (a.last !== w.last) begin
        $display("%0t: last_edge exp %b got %b", $time, w.last, a.last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic signed [15:0] ref_x_i, ref_y_i, ref_z_i;
  logic [15:0]        box_length_i, box_width_i, box_height_i;
  logic [15:0]        pitch_angle_i, yaw_angle_i, roll_angle_i;
  logic [1:0]         anchor_mode_i;
  logic [31:0]        edge_color_i;
  logic               empty;
  logic               pop;
  logic signed [13:0] x_start_o, y_start_o, x_end_o, y_end_o;
  logic [31:0]        line_color_o;
  logic               last_edge_o;

  edge_scoreboard board;
  int             send_idle_pct;  // chance of a gap before each box, percent
  int             recv_idle_pct;  // chance of pop low in a cycle, percent
  int             edges_seen;
  longint         cycles;

  box_wireframe_transform dut (
    .clk_i, .rst_ni, .push, .full,
    .ref_x_i, .ref_y_i, .ref_z_i,
    .box_length_i, .box_width_i, .box_height_i,
    .pitch_angle_i, .yaw_angle_i, .roll_angle_i,
    .anchor_mode_i, .edge_color_i,
    .empty, .pop,
    .x_start_o, .y_start_o, .x_end_o, .y_end_o,
    .line_color_o, .last_edge_o
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Offer one box and hold it until the transfer happens. Random gaps go in front.
  task automatic send_box(box_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push          <= 1'b1;
    ref_x_i       <= b.rx;
    ref_y_i       <= b.ry;
    ref_z_i       <= b.rz;
    box_length_i  <= b.len;
    box_width_i   <= b.wid;
    box_height_i  <= b.hgt;
    pitch_angle_i <= b.pitch;
    yaw_angle_i   <= b.yaw;
    roll_angle_i  <= b.roll;
    anchor_mode_i <= b.anchor;
    edge_color_i  <= b.color;
    do @(posedge clk_i); while (full);
    board.note_box(b);
  endtask

  function automatic box_t make_box(logic signed [15:0] r, logic [15:0] ext,
                                    logic [15:0] ang, logic [1:0] anc, logic [31:0] col);
    box_t b;
    b.rx = r; b.ry = -r; b.rz = r;
    b.len = ext; b.wid = ext; b.hgt = ext;
    b.pitch = ang; b.yaw = ang; b.roll = ang;
    b.anchor = anc;
    b.color  = col;
    return b;
  endfunction

  function automatic box_t random_box();
    box_t b;
    b.rx = 16'($urandom); b.ry = 16'($urandom); b.rz = 16'($urandom);
    b.pitch = 16'($urandom); b.yaw = 16'($urandom); b.roll = 16'($urandom);
    b.anchor = 2'($urandom);
    b.color  = $urandom;
    // most boxes stay on screen; the rest probe saturation with any extent
    if ($urandom_range(99) < 70) begin
      b.rx  = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      b.ry  = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
      b.len = 16'($urandom_range(0, 2000));
      b.wid = 16'($urandom_range(0, 2000));
      b.hgt = 16'($urandom_range(0, 2000));
    end else begin
      b.len = 16'($urandom); b.wid = 16'($urandom); b.hgt = 16'($urandom);
    end
    return b;
  endfunction

  // Result side: check each transfer, then pick pop for the next cycle.
  // Once, after a few boxes, pop is held low for a long stretch so the block backs up.
  initial begin
    edge_t got;
    bit    held;
    held = 1'b0;
    pop  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.xs = x_start_o; got.ys = y_start_o;
        got.xe = x_end_o;   got.ye = y_end_o;
        got.color = line_color_o;
        got.last  = last_edge_o;
        board.check_edge(got);
        edges_seen++;
      end
      if (!held && edges_seen >= 240) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk_i);
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    box_t b;
    int   waited;
    board      = new();
    edges_seen = 0;
    send_idle_pct = 21;
    recv_idle_pct = 64;
    rst_ni = 1'b0;
    push = 1'b0;
    ref_x_i = '0; ref_y_i = '0; ref_z_i = '0;
    box_length_i = '0; box_width_i = '0; box_height_i = '0;
    pitch_angle_i = '0; yaw_angle_i = '0; roll_angle_i = '0;
    anchor_mode_i = '0; edge_color_i = '0;
    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero box, extremes of extents, reference and angles, every anchor
    send_box(make_box(16'sd0, 16'd0, 16'd0, ANCHOR_CENTER, 32'h0));
    send_box(make_box(16'sd0, 16'd160, 16'd0, ANCHOR_CENTER, 32'hFFFF_FFFF));
    send_box(make_box(16'sd0, 16'd160, 16'd0, ANCHOR_TLF, 32'h1234_5678));
    send_box(make_box(16'sd0, 16'd160, 16'd0, ANCHOR_BLF, 32'h8765_4321));
    send_box(make_box(16'sd0, 16'd160, 16'd0, ANCHOR_ALT, 32'hA5A5_5A5A));
    send_box(make_box(16'sd32767, 16'd65535, 16'd0, ANCHOR_CENTER, 32'h1));
    send_box(make_box(-16'sd32768, 16'd65535, 16'd65535, ANCHOR_TLF, 32'h2));
    send_box(make_box(16'sd32767, 16'd0, 16'd65535, ANCHOR_BLF, 32'h3));
    send_box(make_box(16'sd100, 16'd300, 16'd16384, ANCHOR_CENTER, 32'h4));
    send_box(make_box(16'sd100, 16'd300, 16'd32768, ANCHOR_TLF, 32'h5));
    send_box(make_box(16'sd100, 16'd300, 16'd49152, ANCHOR_BLF, 32'h6));
    send_box(make_box(16'sd100, 16'd300, 16'd8192, ANCHOR_ALT, 32'h7));
    send_box(make_box(16'sd100, 16'd300, 16'd16383, ANCHOR_CENTER, 32'h8));
    // ref_z alone changes between these two; results must match
    b = make_box(-16'sd500, 16'd777, 16'd5000, ANCHOR_TLF, 32'h9);
    send_box(b);
    b.rz = 16'sh7FFF;
    send_box(b);
    // single-axis turns
    b = make_box(16'sd0, 16'd400, 16'd0, ANCHOR_CENTER, 32'hA);
    b.pitch = 16'd12000;
    send_box(b);
    b.pitch = 16'd0; b.yaw = 16'd40000;
    send_box(b);
    b.yaw = 16'd0; b.roll = 16'd60000;
    send_box(b);

    // random: three idling regimes, the last with no gaps at all
    for (int i = 0; i < RAND_BOXES; i++) begin
      if (i == RAND_BOXES / 3) begin
        send_idle_pct = 64; recv_idle_pct = 21;
      end else if (i == 2 * RAND_BOXES / 3) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      send_box(random_box());
    end
    push <= 1'b0;

    waited = 0;
    while (board.pending.size() != 0) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
